// ===== src/generational_handle_table_unit_macros.svh =====
// ---------------------------------------------------------------------------
// generational handle table assertion macros
// shared property wrappers clocked on clk_i and disabled during reset
// ---------------------------------------------------------------------------
`ifndef GENERATIONAL_HANDLE_TABLE_UNIT_MACROS_SVH
`define GENERATIONAL_HANDLE_TABLE_UNIT_MACROS_SVH

// same-cycle implication
`define GHT_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define GHT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/ght_pkg.sv =====
// ---------------------------------------------------------------------------
// ght_pkg
// shared types and constants of the generational handle table
// ---------------------------------------------------------------------------
`default_nettype none

package ght_pkg;

  localparam int SLOTS_DEFAULT    = 256;
  localparam int GEN_BITS_DEFAULT = 16;

  localparam int OWNER_W  = 32;
  localparam int TABLE_W  = 16;
  localparam int HSLOT_W  = 8;
  localparam int HGEN_W   = 16;
  localparam int CMD_W    = 2;
  localparam int S_DATA_W = 72;
  localparam int M_DATA_W = 72;

  typedef enum logic [CMD_W-1:0] {
    CMD_ATTACH  = 2'd0,
    CMD_RESOLVE = 2'd1,
    CMD_RELEASE = 2'd2
  } cmd_e;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_e;

  typedef struct packed {
    logic handle_ok;
    logic table_ok;
  } chk_t;

endpackage

`default_nettype wire

// ===== src/ght_check.sv =====
// ---------------------------------------------------------------------------
// ght_check
// handle validation and generation advance for one slot entry
// ---------------------------------------------------------------------------
`default_nettype none

module ght_check #(
  parameter int GEN_BITS = ght_pkg::GEN_BITS_DEFAULT,
  parameter int CNT_W    = 9,
  parameter int CMP_W    = 9
) (
  input  wire logic [ght_pkg::HSLOT_W-1:0] slot_i,
  input  wire logic [ght_pkg::HGEN_W-1:0]  gen_i,
  input  wire logic [ght_pkg::TABLE_W-1:0] table_i,
  input  wire logic [ght_pkg::TABLE_W-1:0] table_id_i,
  input  wire logic [CNT_W-1:0]            used_count_i,
  input  wire logic                        live_i,
  input  wire logic [GEN_BITS-1:0]         gen_rd_i,
  output ght_pkg::chk_t                    chk_o,
  output logic      [GEN_BITS-1:0]         next_gen_o
);

  logic                in_range;
  logic                gen_match;
  logic [GEN_BITS-1:0] gen_inc;

  assign in_range  = CMP_W'(slot_i) < CMP_W'(used_count_i);
  assign gen_match = gen_rd_i == GEN_BITS'(gen_i);

  assign chk_o.handle_ok = in_range && live_i && gen_match;
  assign chk_o.table_ok  = table_i == table_id_i;

  // generation wraps past all ones to 1
  assign gen_inc    = gen_rd_i + GEN_BITS'(1);
  assign next_gen_o = (gen_inc == '0) ? GEN_BITS'(1) : gen_inc;

endmodule

`default_nettype wire

// ===== src/generational_handle_table_unit.sv =====
// ---------------------------------------------------------------------------
// generational_handle_table_unit
// slot table handing out handles of table id, slot index and generation
// ---------------------------------------------------------------------------
// channel   dir  fields
// s_axis    in   tuser: cmd; tdata: owner_ref, handle_table, handle_slot, handle_gen
// m_axis    out  tuser: status; tdata: out_table, out_slot, out_gen, owner_out
// cfg       in   data: table_id
//
// each transaction is accept plus slot memory read, then execute and write back
// to the single-port slot memory; no new transaction is accepted until it is done
// the execute step holds while the output register holds a result not yet taken
// no clearing pass after reset: slots at or above the fill count are never used
// configuration writes are taken every cycle
// ---------------------------------------------------------------------------
`default_nettype none

`include "generational_handle_table_unit_macros.svh"

module generational_handle_table_unit #(
  parameter int SLOTS    = ght_pkg::SLOTS_DEFAULT,
  parameter int GEN_BITS = ght_pkg::GEN_BITS_DEFAULT
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         s_axis_tvalid,
  output logic                              s_axis_tready,
  // owner_ref, handle_table, handle_slot, handle_gen
  input  wire logic [ght_pkg::S_DATA_W-1:0] s_axis_tdata,
  // cmd
  input  wire logic [ght_pkg::CMD_W-1:0]    s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  wire logic                         m_axis_tready,
  // out_table, out_slot, out_gen, owner_out
  output logic      [ght_pkg::M_DATA_W-1:0] m_axis_tdata,
  // status
  output logic      [0:0]                   m_axis_tuser,
  input  wire logic                         cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire logic [ght_pkg::TABLE_W-1:0]  cfg_data_i
);

  localparam int IDX_W  = $clog2(SLOTS);
  localparam int CNT_W  = $clog2(SLOTS + 1);
  localparam int CMP_W  = (CNT_W > ght_pkg::HSLOT_W) ? CNT_W : ght_pkg::HSLOT_W;
  localparam int OWN_W  = ght_pkg::OWNER_W;
  localparam int TAB_W  = ght_pkg::TABLE_W;
  localparam int SLOT_W = ght_pkg::HSLOT_W;
  localparam int OGEN_W = ght_pkg::HGEN_W;

  ght_pkg::state_e state_q, state_d;

  logic [TAB_W-1:0] table_id_q;
  logic [CNT_W-1:0] free_head_q, free_head_d;
  logic [CNT_W-1:0] used_count_q, used_count_d;

  ght_pkg::cmd_e     cmd_q;
  logic [OWN_W-1:0]  owner_q;
  logic [TAB_W-1:0]  htab_q;
  logic [SLOT_W-1:0] hslot_q;
  logic [OGEN_W-1:0] hgen_q;

  logic [OWN_W-1:0]    owner_mem [SLOTS];
  logic [GEN_BITS-1:0] gen_mem   [SLOTS];
  logic                live_mem  [SLOTS];
  logic [CNT_W-1:0]    link_mem  [SLOTS];

  logic [OWN_W-1:0]    rd_owner_q;
  logic [GEN_BITS-1:0] rd_gen_q;
  logic                rd_live_q;
  logic [CNT_W-1:0]    rd_link_q;

  logic                in_fire;
  logic                exec_go;
  logic [CMP_W-1:0]    in_slot_ext;
  logic [CMP_W-1:0]    q_slot_ext;
  logic [IDX_W-1:0]    rd_addr;

  logic                wr_en;
  logic [IDX_W-1:0]    wr_addr;
  logic [OWN_W-1:0]    wr_owner;
  logic [GEN_BITS-1:0] wr_gen;
  logic                wr_live;
  logic [CNT_W-1:0]    wr_link;

  logic [CNT_W-1:0]    alloc_idx;
  logic [CMP_W-1:0]    alloc_ext;
  logic [GEN_BITS-1:0] alloc_gen;

  logic                res_status;
  logic [TAB_W-1:0]    res_table;
  logic [SLOT_W-1:0]   res_slot;
  logic [OGEN_W-1:0]   res_gen;
  logic [OWN_W-1:0]    res_owner;

  logic                m_tvalid_q;
  logic                m_status_q;
  logic [ght_pkg::M_DATA_W-1:0] m_tdata_q;

  ght_pkg::chk_t       chk;
  logic [GEN_BITS-1:0] next_gen;

  // handshakes
  assign in_fire     = s_axis_tvalid && s_axis_tready;
  assign exec_go     = (state_q == ght_pkg::ST_EXEC) && (!m_tvalid_q || m_axis_tready);
  assign cfg_ready_o = 1'b1;

  // sequencer next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ght_pkg::ST_IDLE: begin
        if (in_fire) begin
          state_d = ght_pkg::ST_EXEC;
        end
      end
      ght_pkg::ST_EXEC: begin
        if (exec_go) begin
          state_d = ght_pkg::ST_IDLE;
        end
      end
      default: state_d = ght_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    s_axis_tready = 1'b0;
    unique case (state_q)
      ght_pkg::ST_IDLE: s_axis_tready = 1'b1;
      ght_pkg::ST_EXEC: s_axis_tready = 1'b0;
      default:          s_axis_tready = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ght_pkg::ST_IDLE;
      table_id_q   <= '0;
      free_head_q  <= CNT_W'(SLOTS);
      used_count_q <= '0;
    end else begin
      state_q      <= state_d;
      free_head_q  <= free_head_d;
      used_count_q <= used_count_d;
      if (cfg_valid_i) begin
        table_id_q <= cfg_data_i;
      end
    end
  end

  // transaction capture
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cmd_q   <= ght_pkg::cmd_e'(s_axis_tuser);
      owner_q <= s_axis_tdata[31:0];
      htab_q  <= s_axis_tdata[47:32];
      hslot_q <= s_axis_tdata[55:48];
      hgen_q  <= s_axis_tdata[71:56];
    end
  end

  // slot memory read address
  assign in_slot_ext = CMP_W'(s_axis_tdata[55:48]);
  assign q_slot_ext  = CMP_W'(hslot_q);

  always_comb begin
    if (ght_pkg::cmd_e'(s_axis_tuser) == ght_pkg::CMD_ATTACH) begin
      rd_addr = free_head_q[IDX_W-1:0];
    end else begin
      rd_addr = in_slot_ext[IDX_W-1:0];
    end
  end

  // slot memory
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      rd_owner_q <= owner_mem[rd_addr];
      rd_gen_q   <= gen_mem[rd_addr];
      rd_live_q  <= live_mem[rd_addr];
      rd_link_q  <= link_mem[rd_addr];
    end
    if (wr_en) begin
      owner_mem[wr_addr] <= wr_owner;
      gen_mem[wr_addr]   <= wr_gen;
      live_mem[wr_addr]  <= wr_live;
      link_mem[wr_addr]  <= wr_link;
    end
  end

  ght_check #(
    .GEN_BITS (GEN_BITS),
    .CNT_W    (CNT_W),
    .CMP_W    (CMP_W)
  ) u_check (
    .slot_i       (hslot_q),
    .gen_i        (hgen_q),
    .table_i      (htab_q),
    .table_id_i   (table_id_q),
    .used_count_i (used_count_q),
    .live_i       (rd_live_q),
    .gen_rd_i     (rd_gen_q),
    .chk_o        (chk),
    .next_gen_o   (next_gen)
  );

  assign alloc_ext = CMP_W'(alloc_idx);

  // execute step
  always_comb begin
    wr_en        = 1'b0;
    wr_addr      = q_slot_ext[IDX_W-1:0];
    wr_owner     = owner_q;
    wr_gen       = rd_gen_q;
    wr_live      = 1'b0;
    wr_link      = rd_link_q;
    free_head_d  = free_head_q;
    used_count_d = used_count_q;
    alloc_idx    = free_head_q;
    alloc_gen    = rd_gen_q;
    res_status   = 1'b1;
    res_table    = '0;
    res_slot     = '0;
    res_gen      = '0;
    res_owner    = '0;
    if (exec_go) begin
      unique case (cmd_q)
        ght_pkg::CMD_ATTACH: begin
          if (free_head_q < CNT_W'(SLOTS)) begin
            alloc_idx   = free_head_q;
            alloc_gen   = rd_gen_q;
            free_head_d = (rd_link_q > CNT_W'(SLOTS)) ? CNT_W'(SLOTS) : rd_link_q;
            wr_en       = 1'b1;
          end else if (used_count_q < CNT_W'(SLOTS)) begin
            // fresh slot, never written
            alloc_idx    = used_count_q;
            alloc_gen    = GEN_BITS'(1);
            used_count_d = used_count_q + CNT_W'(1);
            wr_en        = 1'b1;
          end
          if (wr_en) begin
            wr_addr    = alloc_idx[IDX_W-1:0];
            wr_owner   = owner_q;
            wr_gen     = alloc_gen;
            wr_live    = 1'b1;
            res_status = 1'b0;
            res_table  = table_id_q;
            res_slot   = alloc_ext[SLOT_W-1:0];
            res_gen    = OGEN_W'(alloc_gen);
          end
        end
        ght_pkg::CMD_RESOLVE: begin
          if (chk.handle_ok && chk.table_ok) begin
            res_status = 1'b0;
            res_owner  = rd_owner_q;
          end
        end
        ght_pkg::CMD_RELEASE: begin
          if (chk.handle_ok) begin
            wr_en       = 1'b1;
            wr_addr     = q_slot_ext[IDX_W-1:0];
            wr_owner    = '0;
            wr_gen      = next_gen;
            wr_live     = 1'b0;
            wr_link     = free_head_q;
            free_head_d = q_slot_ext[CNT_W-1:0];
            res_status  = 1'b0;
          end
        end
        default: res_status = 1'b1;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_tvalid_q <= 1'b0;
    end else if (exec_go) begin
      m_tvalid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_tvalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec_go) begin
      m_status_q <= res_status;
      m_tdata_q  <= {res_owner, res_gen, res_slot, res_table};
    end
  end

  assign m_axis_tvalid   = m_tvalid_q;
  assign m_axis_tdata    = m_tdata_q;
  assign m_axis_tuser[0] = m_status_q;

  `GHT_ASSERT_IMPL(a_used_bound, 1'b1, used_count_q <= CNT_W'(SLOTS), "fill count past capacity")
  `GHT_ASSERT_IMPL(a_head_bound, 1'b1, free_head_q <= CNT_W'(SLOTS), "free head out of range")
  `GHT_ASSERT_NEXT(a_used_mono, 1'b1, used_count_q >= $past(used_count_q), "fill count shrank")
  `GHT_ASSERT_NEXT(a_fire_exec, in_fire, state_q == ght_pkg::ST_EXEC, "accept without execute")
  `GHT_ASSERT_IMPL(a_result_src, $rose(m_axis_tvalid), $past(exec_go), "result without execute")

endmodule

`default_nettype wire
